[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared codes, field widths and the result record of the sorted priority
// queue unit.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int MODE_W   = 2;
	localparam int ID_W     = 16;
	localparam int PRIO_W   = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT     = 2'd0,
		MODE_REMOVE_PRI = 2'd1,
		MODE_REMOVE_TOP = 2'd2,
		MODE_NOP        = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_INS   = 4'b0010,
		S_PURGE = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	typedef struct packed {
		status_t             status;
		logic [COUNT_W-1:0]  removed_count;
		logic [COUNT_W-1:0]  occupancy;
		logic                head_valid;
		logic [ID_W-1:0]     head_id;
		logic [PRIO_W-1:0]   head_priority;
	} result_t;

endpackage

[hw/rtl/spq_store.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue entry store
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module spq_store #(
	parameter int CAPACITY = 16,
	parameter int ID_W     = 16,
	parameter int PRIO_W   = 8
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(CAPACITY)-1:0] waddr,
	input  logic [ID_W-1:0]             wid,
	input  logic [PRIO_W-1:0]           wprio,
	input  logic [$clog2(CAPACITY)-1:0] raddr,
	output logic [ID_W-1:0]             rid,
	output logic [PRIO_W-1:0]           rprio
);

	logic [ID_W-1:0]   id_mem   [CAPACITY];
	logic [PRIO_W-1:0] prio_mem [CAPACITY];
	logic [ID_W-1:0]   rid_q;
	logic [PRIO_W-1:0] rprio_q;

	always_ff @(posedge clk) begin
		if (we) begin
			id_mem[waddr]   <= wid;
			prio_mem[waddr] <= wprio;
		end
		rid_q   <= id_mem[raddr];
		rprio_q <= prio_mem[raddr];
	end

	assign rid   = rid_q;
	assign rprio = rprio_q;

endmodule

[hw/rtl/spq_seq.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue sequencer
// Walks the entry store one entry per cycle with a single compare unit to
// insert in order or to remove and compact all entries of one priority.
// ----------------------------------------------------------------------------
module spq_seq #(
	parameter int CAPACITY = 16,
	parameter int ID_W     = 16,
	parameter int PRIO_W   = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  spq_pkg::mode_t          mode,
	input  logic [ID_W-1:0]         entry_id,
	input  logic [PRIO_W-1:0]       priority_req,
	output logic                    res_valid,
	input  logic                    res_ready,
	output spq_pkg::result_t        res
);

	localparam int AddrW  = $clog2(CAPACITY);
	localparam int CntW   = $clog2(CAPACITY + 1);
	localparam int CountW = spq_pkg::COUNT_W;
	localparam int IdF    = spq_pkg::ID_W;
	localparam int PrioF  = spq_pkg::PRIO_W;

	spq_pkg::state_t  state_q;
	logic [CntW-1:0]  count_q;
	logic [CntW-1:0]  k_q;
	logic [CntW-1:0]  w_q;
	logic [CntW-1:0]  gone_q;
	logic [ID_W-1:0]  new_id_q;
	logic [PRIO_W-1:0] new_prio_q;
	spq_pkg::status_t status_q;
	logic [ID_W-1:0]  head_id_q;
	logic [PRIO_W-1:0] head_prio_q;

	logic              mem_we;
	logic [AddrW-1:0]  mem_waddr;
	logic [ID_W-1:0]   mem_wid;
	logic [PRIO_W-1:0] mem_wprio;
	logic [AddrW-1:0]  mem_raddr;
	logic [ID_W-1:0]   rd_id;
	logic [PRIO_W-1:0] rd_prio;

	logic accept;
	logic full;
	logic empty;
	logic is_remove;
	logic shift;
	logic drop;
	logic [CntW-1:0] k_back;

	spq_store #(
		.CAPACITY (CAPACITY),
		.ID_W     (ID_W),
		.PRIO_W   (PRIO_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wid   (mem_wid),
		.wprio (mem_wprio),
		.raddr (mem_raddr),
		.rid   (rd_id),
		.rprio (rd_prio)
	);

	assign in_ready  = (state_q == spq_pkg::S_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CntW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign is_remove = (mode == spq_pkg::MODE_REMOVE_PRI) || (mode == spq_pkg::MODE_REMOVE_TOP);
	assign shift     = (state_q == spq_pkg::S_INS) && (k_q != '0) && (rd_prio < new_prio_q);
	assign drop      = (state_q == spq_pkg::S_PURGE) && (rd_prio == new_prio_q);
	assign k_back    = k_q - CntW'(2);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wid   = new_id_q;
		mem_wprio = new_prio_q;
		mem_raddr = '0;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (accept && mode == spq_pkg::MODE_INSERT && !full) begin
					if (empty) begin
						mem_we    = 1'b1;
						mem_wid   = entry_id;
						mem_wprio = priority_req;
					end else begin
						mem_raddr = AddrW'(count_q - CntW'(1));
					end
				end
			end
			spq_pkg::S_INS: begin
				mem_we    = 1'b1;
				mem_waddr = k_q[AddrW-1:0];
				if (shift) begin
					mem_wid   = rd_id;
					mem_wprio = rd_prio;
					mem_raddr = k_back[AddrW-1:0];
				end
			end
			spq_pkg::S_PURGE: begin
				mem_raddr = k_q[AddrW-1:0];
				if (!drop) begin
					mem_we    = 1'b1;
					mem_waddr = w_q[AddrW-1:0];
					mem_wid   = rd_id;
					mem_wprio = rd_prio;
				end
			end
			spq_pkg::S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				spq_pkg::S_IDLE: begin
					if (accept) begin
						if (mode == spq_pkg::MODE_INSERT) begin
							if (full) begin
								state_q <= spq_pkg::S_DONE;
							end else if (empty) begin
								count_q <= CntW'(1);
								state_q <= spq_pkg::S_DONE;
							end else begin
								state_q <= spq_pkg::S_INS;
							end
						end else if (is_remove && !empty) begin
							state_q <= spq_pkg::S_PURGE;
						end else begin
							state_q <= spq_pkg::S_DONE;
						end
					end
				end
				spq_pkg::S_INS: begin
					if (!shift) begin
						count_q <= count_q + CntW'(1);
						state_q <= spq_pkg::S_DONE;
					end
				end
				spq_pkg::S_PURGE: begin
					if (k_q == count_q) begin
						count_q <= drop ? w_q : w_q + CntW'(1);
						state_q <= spq_pkg::S_DONE;
					end
				end
				spq_pkg::S_DONE: begin
					if (res_ready) begin
						state_q <= spq_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= spq_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= spq_pkg::STATUS_OK;
			gone_q   <= '0;
			w_q      <= '0;
			new_id_q <= entry_id;
			if (mode == spq_pkg::MODE_REMOVE_TOP) begin
				new_prio_q <= head_prio_q;
			end else begin
				new_prio_q <= priority_req;
			end
			if (mode == spq_pkg::MODE_INSERT) begin
				k_q <= count_q;
				if (full) begin
					status_q <= spq_pkg::STATUS_FULL;
				end
			end else begin
				k_q <= CntW'(1);
				if (is_remove && empty) begin
					status_q <= spq_pkg::STATUS_EMPTY;
				end
			end
		end else if (shift) begin
			k_q <= k_q - CntW'(1);
		end else if (state_q == spq_pkg::S_PURGE) begin
			k_q <= k_q + CntW'(1);
			if (drop) begin
				gone_q <= gone_q + CntW'(1);
			end else begin
				w_q <= w_q + CntW'(1);
			end
		end
		if (mem_we && mem_waddr == '0) begin
			head_id_q   <= mem_wid;
			head_prio_q <= mem_wprio;
		end
	end

	assign res_valid             = (state_q == spq_pkg::S_DONE);
	assign res.status            = status_q;
	assign res.removed_count     = CountW'(gone_q);
	assign res.occupancy         = CountW'(count_q);
	assign res.head_valid        = !empty;
	assign res.head_id           = empty ? '0 : IdF'(head_id_q);
	assign res.head_priority     = empty ? '0 : PrioF'(head_prio_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_purge_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spq_pkg::S_PURGE |-> (w_q < k_q) && (k_q <= count_q))
		else $error("compaction write pointer passed read pointer");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spq_pkg::S_INS && !shift) |=> count_q == $past(count_q) + CntW'(1))
		else $error("insert did not add exactly one entry");

	a_purge_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spq_pkg::S_PURGE && k_q == count_q) |=>
		count_q + gone_q == $past(count_q))
		else $error("removed and kept entries do not add up");

	a_insert_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spq_pkg::S_INS |-> !full)
		else $error("insert walk started on a full queue");

endmodule

[hw/rtl/sorted_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue of (id, priority) entries kept in descending priority order,
// first-in first-out among equal priorities, with one result per item.
// ----------------------------------------------------------------------------
//  Channel  Signals                                   Direction
//  in       in_valid, in_ready, mode, entry_id,       into the unit
//           priority_req
//  out      out_valid, out_ready, status,              out of the unit
//           removed_count, occupancy, head_valid,
//           head_id, head_priority
//
// An insert into a non-empty queue walks back over each entry of lower priority
// and moves it back one place, and an insert into an empty queue writes directly;
// a removal walks every entry held.
// Both walks are set by the single read and write port of the entry store.
// A full insert, a removal on an empty queue and the unused mode go straight to the result.
// Reset clears the entry count but not the entry store; the store needs no clearing pass.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
	parameter int CAPACITY  = 16,
	parameter int PRIO_BITS = 8,
	parameter int ID_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [spq_pkg::MODE_W-1:0]    mode,
	input  logic [spq_pkg::ID_W-1:0]      entry_id,
	input  logic [spq_pkg::PRIO_W-1:0]    priority_req,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [spq_pkg::STATUS_W-1:0]  status,
	output logic [spq_pkg::COUNT_W-1:0]   removed_count,
	output logic [spq_pkg::COUNT_W-1:0]   occupancy,
	output logic                          head_valid,
	output logic [spq_pkg::ID_W-1:0]      head_id,
	output logic [spq_pkg::PRIO_W-1:0]    head_priority
);

	localparam int IdW   = (ID_BITS < spq_pkg::ID_W) ? ID_BITS : spq_pkg::ID_W;
	localparam int PrioW = (PRIO_BITS < spq_pkg::PRIO_W) ? PRIO_BITS : spq_pkg::PRIO_W;

	logic             res_valid;
	logic             res_ready;
	spq_pkg::result_t res;
	spq_pkg::result_t out_q;
	logic             out_valid_q;

	spq_seq #(
		.CAPACITY (CAPACITY),
		.ID_W     (IdW),
		.PRIO_W   (PrioW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (spq_pkg::mode_t'(mode)),
		.entry_id     (entry_id[IdW-1:0]),
		.priority_req (priority_req[PrioW-1:0]),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign removed_count = out_q.removed_count;
	assign occupancy     = out_q.occupancy;
	assign head_valid    = out_q.head_valid;
	assign head_id       = out_q.head_id;
	assign head_priority = out_q.head_priority;

endmodule

[tb/queue_result_checker.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue result checker
// Watches both channels of the sorted priority queue unit, keeps a shadow copy
// of the sorted entry list, predicts the result of every accepted command and
// compares each delivered result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module queue_result_checker #(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [spq_pkg::MODE_W-1:0]    mode,
	input  logic [spq_pkg::ID_W-1:0]      entry_id,
	input  logic [spq_pkg::PRIO_W-1:0]    priority_req,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [spq_pkg::STATUS_W-1:0]  status,
	input  logic [spq_pkg::COUNT_W-1:0]   removed_count,
	input  logic [spq_pkg::COUNT_W-1:0]   occupancy,
	input  logic                          head_valid,
	input  logic [spq_pkg::ID_W-1:0]      head_id,
	input  logic [spq_pkg::PRIO_W-1:0]    head_priority,
	output int                            failures,
	output int                            pending
);
	import spq_pkg::*;

	logic [ID_W-1:0]   shadow_ids [CAPACITY];
	logic [PRIO_W-1:0] shadow_prios [CAPACITY];
	int                shadow_count;
	result_t           predicted_results [$];
	result_t           oldest;

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		$display("mismatch on %s: got %0d, expected %0d", field, got, want);
		failures++;
	endtask

	function automatic result_t apply_command(input mode_t op, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] pri);
		result_t           res;
		int                pos;
		int                k;
		int                wr;
		int                gone;
		logic [PRIO_W-1:0] target;
		res = '0;
		res.status = STATUS_OK;
		gone = 0;
		case (op)
			MODE_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					res.status = STATUS_FULL;
				end else begin
					pos = 0;
					while (pos < shadow_count && shadow_prios[pos] >= pri)
						pos++;
					for (k = shadow_count; k > pos; k--) begin
						shadow_ids[k] = shadow_ids[k-1];
						shadow_prios[k] = shadow_prios[k-1];
					end
					shadow_ids[pos] = id;
					shadow_prios[pos] = pri;
					shadow_count++;
				end
			end
			MODE_REMOVE_PRI, MODE_REMOVE_TOP: begin
				if (shadow_count == 0) begin
					res.status = STATUS_EMPTY;
				end else begin
					target = (op == MODE_REMOVE_PRI) ? pri : shadow_prios[0];
					wr = 0;
					for (k = 0; k < shadow_count; k++) begin
						if (shadow_prios[k] == target) begin
							gone++;
						end else begin
							shadow_ids[wr] = shadow_ids[k];
							shadow_prios[wr] = shadow_prios[k];
							wr++;
						end
					end
					shadow_count = wr;
				end
			end
			default: begin
			end
		endcase
		res.removed_count = COUNT_W'(gone);
		res.occupancy = COUNT_W'(shadow_count);
		if (shadow_count > 0) begin
			res.head_valid = 1'b1;
			res.head_id = shadow_ids[0];
			res.head_priority = shadow_prios[0];
		end
		return res;
	endfunction

	// The result register cannot deliver a command's result at the edge that
	// accepts it, so delivered results are matched before new predictions land.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count = 0;
			predicted_results.delete();
			failures = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("unexpected result transfer", occupancy, 0);
				end else begin
					oldest = predicted_results.pop_front();
					if (status !== oldest.status)
						report_mismatch("status", status, oldest.status);
					if (removed_count !== oldest.removed_count)
						report_mismatch("removed_count", removed_count, oldest.removed_count);
					if (occupancy !== oldest.occupancy)
						report_mismatch("occupancy", occupancy, oldest.occupancy);
					if (head_valid !== oldest.head_valid)
						report_mismatch("head_valid", head_valid, oldest.head_valid);
					if (head_id !== oldest.head_id)
						report_mismatch("head_id", head_id, oldest.head_id);
					if (head_priority !== oldest.head_priority)
						report_mismatch("head_priority", head_priority, oldest.head_priority);
				end
			end
			if (in_valid && in_ready)
				predicted_results.push_back(apply_command(mode_t'(mode), entry_id,
					priority_req));
			pending = predicted_results.size();
		end
	end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives directed commands covering empty and full queues, ties, absent
// priorities and the unused mode, then phases of random commands with varying
// insert and removal mixes, while both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
	import spq_pkg::*;

	localparam int RANDOM_ITEMS = 1800;
	localparam int PHASE_LEN    = 50;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [MODE_W-1:0]  mode = '0;
	logic [ID_W-1:0]    entry_id = '0;
	logic [PRIO_W-1:0]  priority_req = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0] removed_count;
	logic [COUNT_W-1:0] occupancy;
	logic               head_valid;
	logic [ID_W-1:0]    head_id;
	logic [PRIO_W-1:0]  head_priority;
	int                 failures;
	int                 pending;
	bit                 quiet_phase = 1'b0;
	int                 stall_left = 0;

	sorted_priority_queue_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.entry_id(entry_id),
		.priority_req(priority_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.removed_count(removed_count),
		.occupancy(occupancy),
		.head_valid(head_valid),
		.head_id(head_id),
		.head_priority(head_priority)
	);

	queue_result_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.entry_id(entry_id),
		.priority_req(priority_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.removed_count(removed_count),
		.occupancy(occupancy),
		.head_valid(head_valid),
		.head_id(head_id),
		.head_priority(head_priority),
		.failures(failures),
		.pending(pending)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!quiet_phase && $urandom_range(0, 2) == 0)
				stall_left = pick_gap();
		end
	end

	task automatic send_item(input mode_t op, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] pri);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode <= op;
		entry_id <= id;
		priority_req <= pri;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	initial begin
		logic [PRIO_W-1:0] pool [4];
		logic [PRIO_W-1:0] pri;
		logic [ID_W-1:0]   id;
		int                insert_pct;
		int                r;
		int                k;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(MODE_REMOVE_TOP, 16'h1234, 8'h00);
		send_item(MODE_REMOVE_PRI, 16'h0000, 8'hFF);
		send_item(MODE_NOP, 16'hFFFF, 8'h80);
		// Three priority levels repeat, so every level ends up with several ties.
		for (k = 0; k < 16; k++) begin
			id = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : ID_W'(k * 4099);
			pri = (k % 3 == 0) ? 8'hFF : (k % 3 == 1) ? 8'h00 : 8'h80;
			send_item(MODE_INSERT, id, pri);
		end
		send_item(MODE_INSERT, 16'hBEEF, 8'hFF);
		send_item(MODE_NOP, 16'h5A5A, 8'h00);
		send_item(MODE_REMOVE_PRI, 16'h0000, 8'h55);
		send_item(MODE_REMOVE_TOP, 16'h0000, 8'h00);
		send_item(MODE_REMOVE_PRI, 16'h0000, 8'h80);

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % PHASE_LEN == 0) begin
				for (r = 0; r < 4; r++)
					pool[r] = PRIO_W'($urandom);
				case ($urandom_range(0, 3))
					0: insert_pct = 25;
					1: insert_pct = 50;
					2: insert_pct = 75;
					default: insert_pct = 90;
				endcase
				quiet_phase = ($urandom_range(0, 4) == 0);
			end
			id = ID_W'($urandom);
			pri = ($urandom_range(0, 4) == 0) ? PRIO_W'($urandom) : pool[$urandom_range(0, 3)];
			if ($urandom_range(0, 99) < insert_pct) begin
				send_item(MODE_INSERT, id, pri);
			end else begin
				r = $urandom_range(0, 19);
				if (r == 0)
					send_item(MODE_NOP, id, pri);
				else if (r < 10)
					send_item(MODE_REMOVE_PRI, id, pri);
				else
					send_item(MODE_REMOVE_TOP, id, pri);
			end
		end
		in_valid <= 1'b0;
		quiet_phase = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#15000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/spq_pkg.sv
hw/rtl/spq_store.sv
hw/rtl/spq_seq.sv
hw/rtl/sorted_priority_queue_unit.sv
tb/queue_result_checker.sv
tb/testbench.sv
